// ===== design/i2cras_pkg.sv =====
`default_nettype none

package i2cras_pkg;

    // Input item codes
    localparam logic [1:0] MODE_WRITE     = 2'd0;
    localparam logic [1:0] MODE_READ      = 2'd1;
    localparam logic [1:0] MODE_BYTE_DONE = 2'd2;

    // Finished transaction status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NODEV   = 2'd1;
    localparam logic [1:0] STATUS_BADACK  = 2'd2;

    // Result kinds
    localparam logic RESULT_CMD  = 1'b0;
    localparam logic RESULT_DONE = 1'b1;

    // R/W bit handling of the device address byte
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
    localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

    // Output queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       result_kind;
        logic       cmd_start;
        logic       cmd_stop;
        logic       cmd_read;
        logic       cmd_write;
        logic       cmd_nack;
        logic [7:0] cmd_byte;
        logic [1:0] status;
        logic [7:0] read_value;
        logic       last;
    } result_t;

    // Results produced by one input item
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    function automatic result_t make_cmd(
        input logic       start,
        input logic       stop,
        input logic       rd,
        input logic       wr,
        input logic       nack,
        input logic [7:0] data,
        input logic       last
    );
        result_t r;
        r             = '0;
        r.result_kind = RESULT_CMD;
        r.cmd_start   = start;
        r.cmd_stop    = stop;
        r.cmd_read    = rd;
        r.cmd_write   = wr;
        r.cmd_nack    = nack;
        r.cmd_byte    = data;
        r.last        = last;
        return r;
    endfunction

    function automatic result_t make_done(
        input logic [1:0] status,
        input logic [7:0] value
    );
        result_t r;
        r             = '0;
        r.result_kind = RESULT_DONE;
        r.status      = status;
        r.read_value  = value;
        r.last        = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/i2cras_seq.sv =====
`default_nettype none

module i2cras_seq (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_fire,
    input  wire  [1:0]           mode,
    input  wire  [7:0]           device_addr,
    input  wire  [7:0]           reg_index,
    input  wire  [7:0]           write_value,
    input  wire                  ack_missing,
    input  wire  [7:0]           received_byte,
    output i2cras_pkg::result_pair_t results
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_INDEX = 3'd2,
        PH_VALUE = 3'd3,
        PH_RADDR = 3'd4,
        PH_RDATA = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] device_reg, device_next;
    logic [7:0] index_reg, index_next;
    logic [7:0] value_reg, value_next;

    // Decode one transaction against the current phase
    always_comb begin
        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        device_next  = device_reg;
        index_next   = index_reg;
        value_next   = value_reg;
        results      = '0;
        if (in_fire) begin
            unique case (mode)
                i2cras_pkg::MODE_WRITE, i2cras_pkg::MODE_READ: begin
                    if (phase_reg == PH_IDLE) begin
                        device_next   = device_addr;
                        index_next    = reg_index;
                        value_next    = write_value;
                        is_read_next  = mode[0];
                        results.count = 2'd1;
                        results.first = i2cras_pkg::make_cmd(1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                            device_addr & i2cras_pkg::ADDR_WRITE_MASK, 1'b1);
                        phase_next    = PH_ADDR;
                    end
                end
                i2cras_pkg::MODE_BYTE_DONE: begin
                    unique case (phase_reg)
                        PH_ADDR, PH_RADDR, PH_INDEX, PH_VALUE: begin
                            if (ack_missing) begin
                                // Issue STOP alone, then report the error
                                results.count  = 2'd2;
                                results.first  = i2cras_pkg::make_cmd(1'b0, 1'b1, 1'b0,
                                    1'b0, 1'b0, 8'd0, 1'b0);
                                results.second = i2cras_pkg::make_done(
                                    (phase_reg == PH_ADDR || phase_reg == PH_RADDR) ?
                                    i2cras_pkg::STATUS_NODEV : i2cras_pkg::STATUS_BADACK,
                                    8'd0);
                                phase_next     = PH_IDLE;
                            end else begin
                                results.count = 2'd1;
                                unique case (phase_reg)
                                    PH_ADDR: begin
                                        results.first = i2cras_pkg::make_cmd(1'b0, 1'b0,
                                            1'b0, 1'b1, 1'b0, index_reg, 1'b1);
                                        phase_next    = PH_INDEX;
                                    end
                                    PH_INDEX: begin
                                        if (is_read_reg) begin
                                            results.first = i2cras_pkg::make_cmd(1'b1,
                                                1'b0, 1'b0, 1'b1, 1'b0,
                                                device_reg | i2cras_pkg::ADDR_READ_BIT,
                                                1'b1);
                                            phase_next    = PH_RADDR;
                                        end else begin
                                            results.first = i2cras_pkg::make_cmd(1'b0,
                                                1'b1, 1'b0, 1'b1, 1'b0, value_reg, 1'b1);
                                            phase_next    = PH_VALUE;
                                        end
                                    end
                                    PH_VALUE: begin
                                        results.first = i2cras_pkg::make_done(
                                            i2cras_pkg::STATUS_OK, 8'd0);
                                        phase_next    = PH_IDLE;
                                    end
                                    default: begin
                                        // Address with R/W set acknowledged: read one byte
                                        results.first = i2cras_pkg::make_cmd(1'b0, 1'b1,
                                            1'b1, 1'b0, 1'b1, 8'd0, 1'b1);
                                        phase_next    = PH_RDATA;
                                    end
                                endcase
                            end
                        end
                        PH_RDATA: begin
                            results.count = 2'd1;
                            results.first = i2cras_pkg::make_done(i2cras_pkg::STATUS_OK,
                                received_byte);
                            phase_next    = PH_IDLE;
                        end
                        default: begin
                            // Drop byte-done events while idle
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                    // Drop the unused mode code
                end
            endcase
        end
    end

    // Hold phase and the saved request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            is_read_reg <= 1'b0;
            device_reg  <= 8'd0;
            index_reg   <= 8'd0;
            value_reg   <= 8'd0;
        end else begin
            phase_reg   <= phase_next;
            is_read_reg <= is_read_next;
            device_reg  <= device_next;
            index_reg   <= index_next;
            value_reg   <= value_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2cras_outq.sv =====
`default_nettype none

module i2cras_outq (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire i2cras_pkg::result_pair_t push,
    output logic                      has_room,
    output logic                      out_valid,
    input  wire                       out_ready,
    output i2cras_pkg::result_t       out_data
);

    i2cras_pkg::result_t mem_reg [i2cras_pkg::QUEUE_DEPTH];

    logic [i2cras_pkg::PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [i2cras_pkg::PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [i2cras_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [i2cras_pkg::PTR_W-1:0]   wr_ptr_second;
    logic                           pop;

    // Room for the two results of a failing byte
    assign has_room  = count_reg <= i2cras_pkg::COUNT_W'(i2cras_pkg::QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_second = wr_ptr_reg + i2cras_pkg::PTR_W'(1);
        wr_ptr_next   = wr_ptr_reg + i2cras_pkg::PTR_W'(push.count);
        rd_ptr_next   = rd_ptr_reg + i2cras_pkg::PTR_W'(pop);
        count_next    = count_reg + i2cras_pkg::COUNT_W'(push.count)
                        - i2cras_pkg::COUNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store results in order
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2c_register_access_sequencer_unit.sv =====
`default_nettype none

// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// s_       | s_valid / s_ready  | mode, device_addr, reg_index, write_value,
//          |                    | ack_missing, received_byte
// m_       | m_valid / m_ready  | result_kind, cmd_*, status, read_value, last
//
// One input transaction is accepted per cycle while s_ready is high; its results are
// decoded in the same cycle and written into a four-entry output queue. A failing byte
// yields two results, which the queue drains at one per cycle while m_ready is high.
// s_ready drops while the queue holds more than two results (m_ready low).
// aresetn clears the phase to idle and empties the queue.

module i2c_register_access_sequencer_unit (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [1:0] s_mode,
    input  wire  [7:0] s_device_addr,
    input  wire  [7:0] s_reg_index,
    input  wire  [7:0] s_write_value,
    input  wire        s_ack_missing,
    input  wire  [7:0] s_received_byte,
    output logic       m_valid,
    input  wire        m_ready,
    output logic       m_result_kind,
    output logic       m_cmd_start,
    output logic       m_cmd_stop,
    output logic       m_cmd_read,
    output logic       m_cmd_write,
    output logic       m_cmd_nack,
    output logic [7:0] m_cmd_byte,
    output logic [1:0] m_status,
    output logic [7:0] m_read_value,
    output logic       m_last
);

    i2cras_pkg::result_pair_t results;
    i2cras_pkg::result_t      out_data;
    logic                     in_fire;

    assign in_fire = s_valid && s_ready;

    i2cras_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .mode          (s_mode),
        .device_addr   (s_device_addr),
        .reg_index     (s_reg_index),
        .write_value   (s_write_value),
        .ack_missing   (s_ack_missing),
        .received_byte (s_received_byte),
        .results       (results)
    );

    i2cras_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (results),
        .has_room  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    // Unpack the head result onto the ports
    assign m_result_kind = out_data.result_kind;
    assign m_cmd_start   = out_data.cmd_start;
    assign m_cmd_stop    = out_data.cmd_stop;
    assign m_cmd_read    = out_data.cmd_read;
    assign m_cmd_write   = out_data.cmd_write;
    assign m_cmd_nack    = out_data.cmd_nack;
    assign m_cmd_byte    = out_data.cmd_byte;
    assign m_status      = out_data.status;
    assign m_read_value  = out_data.read_value;
    assign m_last        = out_data.last;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [2:0] {
        BUS_IDLE, BUS_ADDR, BUS_INDEX, BUS_VALUE, BUS_RADDR, BUS_RDATA
    } bus_phase_t;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] device_addr;
        logic [7:0] reg_index;
        logic [7:0] write_value;
        logic       ack_missing;
        logic [7:0] received_byte;
    } bus_event_t;

    // directed row: typed_n < 0 means the predictor supplies the expectation
    typedef struct {
        bus_event_t          ev;
        int                  typed_n;
        i2cras_pkg::result_t typed0;
        i2cras_pkg::result_t typed1;
    } directed_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [7:0] s_device_addr;
    logic [7:0] s_reg_index;
    logic [7:0] s_write_value;
    logic       s_ack_missing;
    logic [7:0] s_received_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_result_kind;
    logic       m_cmd_start;
    logic       m_cmd_stop;
    logic       m_cmd_read;
    logic       m_cmd_write;
    logic       m_cmd_nack;
    logic [7:0] m_cmd_byte;
    logic [1:0] m_status;
    logic [7:0] m_read_value;
    logic       m_last;

    // sequencer model state
    bus_phase_t model_phase;
    logic       model_is_read;
    logic [7:0] model_device;
    logic [7:0] model_index;
    logic [7:0] model_value;

    i2cras_pkg::result_t awaited_results[$];
    directed_row_t       directed_rows[$];
    int                  error_count;
    int                  src_idle_pct;
    int                  sink_stall_pct;

    i2c_register_access_sequencer_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_device_addr   (s_device_addr),
        .s_reg_index     (s_reg_index),
        .s_write_value   (s_write_value),
        .s_ack_missing   (s_ack_missing),
        .s_received_byte (s_received_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_cmd_start     (m_cmd_start),
        .m_cmd_stop      (m_cmd_stop),
        .m_cmd_read      (m_cmd_read),
        .m_cmd_write     (m_cmd_write),
        .m_cmd_nack      (m_cmd_nack),
        .m_cmd_byte      (m_cmd_byte),
        .m_status        (m_status),
        .m_read_value    (m_read_value),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic i2cras_pkg::result_t cmd_word(input logic start, input logic stop,
                                                     input logic rd, input logic wr,
                                                     input logic nack,
                                                     input logic [7:0] data,
                                                     input logic last);
        i2cras_pkg::result_t r;
        r             = '0;
        r.result_kind = i2cras_pkg::RESULT_CMD;
        r.cmd_start   = start;
        r.cmd_stop    = stop;
        r.cmd_read    = rd;
        r.cmd_write   = wr;
        r.cmd_nack    = nack;
        r.cmd_byte    = data;
        r.last        = last;
        return r;
    endfunction

    function automatic i2cras_pkg::result_t done_word(input logic [1:0] code,
                                                      input logic [7:0] value);
        i2cras_pkg::result_t r;
        r             = '0;
        r.result_kind = i2cras_pkg::RESULT_DONE;
        r.status      = code;
        r.read_value  = value;
        r.last        = 1'b1;
        return r;
    endfunction

    // Advance the sequencer state by one accepted transaction and return its results
    task automatic next_bus_results(input bus_event_t ev, output int n,
                                    output i2cras_pkg::result_t r0,
                                    output i2cras_pkg::result_t r1);
        logic [1:0] err_code;
        logic       failed;
        n        = 0;
        r0       = '0;
        r1       = '0;
        failed   = 1'b0;
        err_code = i2cras_pkg::STATUS_OK;
        if (ev.mode == i2cras_pkg::MODE_WRITE || ev.mode == i2cras_pkg::MODE_READ) begin
            if (model_phase == BUS_IDLE) begin
                model_device  = ev.device_addr;
                model_index   = ev.reg_index;
                model_value   = ev.write_value;
                model_is_read = (ev.mode == i2cras_pkg::MODE_READ);
                r0 = cmd_word(1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                              ev.device_addr & i2cras_pkg::ADDR_WRITE_MASK, 1'b1);
                n  = 1;
                model_phase = BUS_ADDR;
            end
        end else if (ev.mode == i2cras_pkg::MODE_BYTE_DONE) begin
            n = 1;
            case (model_phase)
                BUS_ADDR: begin
                    if (ev.ack_missing) begin
                        failed   = 1'b1;
                        err_code = i2cras_pkg::STATUS_NODEV;
                    end else begin
                        r0 = cmd_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, model_index, 1'b1);
                        model_phase = BUS_INDEX;
                    end
                end
                BUS_INDEX: begin
                    if (ev.ack_missing) begin
                        failed   = 1'b1;
                        err_code = i2cras_pkg::STATUS_BADACK;
                    end else if (model_is_read) begin
                        r0 = cmd_word(1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                                      model_device | i2cras_pkg::ADDR_READ_BIT, 1'b1);
                        model_phase = BUS_RADDR;
                    end else begin
                        r0 = cmd_word(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, model_value, 1'b1);
                        model_phase = BUS_VALUE;
                    end
                end
                BUS_VALUE: begin
                    if (ev.ack_missing) begin
                        failed   = 1'b1;
                        err_code = i2cras_pkg::STATUS_BADACK;
                    end else begin
                        r0 = done_word(i2cras_pkg::STATUS_OK, 8'h00);
                        model_phase = BUS_IDLE;
                    end
                end
                BUS_RADDR: begin
                    if (ev.ack_missing) begin
                        failed   = 1'b1;
                        err_code = i2cras_pkg::STATUS_NODEV;
                    end else begin
                        r0 = cmd_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1);
                        model_phase = BUS_RDATA;
                    end
                end
                BUS_RDATA: begin
                    // ack bit ignored on the final byte, the master NACKs it
                    r0 = done_word(i2cras_pkg::STATUS_OK, ev.received_byte);
                    model_phase = BUS_IDLE;
                end
                default: begin
                    n = 0;
                    model_phase = BUS_IDLE;
                end
            endcase
            if (failed) begin
                // STOP-only command ahead of the error status
                r0 = cmd_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
                r1 = done_word(err_code, 8'h00);
                n  = 2;
                model_phase = BUS_IDLE;
            end
        end
    endtask

    function automatic bus_event_t make_event(input logic [1:0] mode, input logic [7:0] dev,
                                              input logic [7:0] idx, input logic [7:0] val,
                                              input logic nak, input logic [7:0] rx);
        bus_event_t ev;
        ev.mode          = mode;
        ev.device_addr   = dev;
        ev.reg_index     = idx;
        ev.write_value   = val;
        ev.ack_missing   = nak;
        ev.received_byte = rx;
        return ev;
    endfunction

    task automatic add_row(input bus_event_t ev, input int typed_n,
                           input i2cras_pkg::result_t t0, input i2cras_pkg::result_t t1);
        directed_row_t row;
        row.ev      = ev;
        row.typed_n = typed_n;
        row.typed0  = t0;
        row.typed1  = t1;
        directed_rows.push_back(row);
    endtask

    // Send one transaction (entered and left at a falling edge)
    task automatic send_event(input bus_event_t ev, input int typed_n,
                              input i2cras_pkg::result_t t0, input i2cras_pkg::result_t t1);
        i2cras_pkg::result_t r0;
        i2cras_pkg::result_t r1;
        int                  n;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_mode          = ev.mode;
        s_device_addr   = ev.device_addr;
        s_reg_index     = ev.reg_index;
        s_write_value   = ev.write_value;
        s_ack_missing   = ev.ack_missing;
        s_received_byte = ev.received_byte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        next_bus_results(ev, n, r0, r1);
        if (typed_n >= 0) begin
            n  = typed_n;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0) awaited_results.push_back(r0);
        if (n > 1) awaited_results.push_back(r1);
        @(negedge aclk);
    endtask

    // Random transaction: mostly well-formed sequences, some noise and early NACKs
    function automatic bus_event_t random_event();
        bus_event_t ev;
        int         pick;
        ev = make_event(2'($urandom_range(3)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        1'($urandom_range(1)), 8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (model_phase == BUS_IDLE) begin
            if (pick < 85) begin
                ev.mode = ($urandom_range(1) != 0) ? i2cras_pkg::MODE_READ
                                                   : i2cras_pkg::MODE_WRITE;
            end else if (pick < 93) begin
                ev.mode = i2cras_pkg::MODE_BYTE_DONE;
            end else begin
                ev.mode = MODE_IGNORED;
            end
        end else begin
            if (pick < 85) begin
                ev.mode        = i2cras_pkg::MODE_BYTE_DONE;
                ev.ack_missing = ($urandom_range(7) == 0);
            end else if (pick < 93) begin
                ev.mode = ($urandom_range(1) != 0) ? i2cras_pkg::MODE_READ
                                                   : i2cras_pkg::MODE_WRITE;
            end else begin
                ev.mode = MODE_IGNORED;
            end
        end
        return ev;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Receiver: drive ready at the falling edge
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        i2cras_pkg::result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual kind %0h byte %0h",
                         $time, m_result_kind, m_cmd_byte);
            end else begin
                want = awaited_results.pop_front();
                check_field("result_kind", int'(want.result_kind), int'(m_result_kind));
                check_field("cmd_start", int'(want.cmd_start), int'(m_cmd_start));
                check_field("cmd_stop", int'(want.cmd_stop), int'(m_cmd_stop));
                check_field("cmd_read", int'(want.cmd_read), int'(m_cmd_read));
                check_field("cmd_write", int'(want.cmd_write), int'(m_cmd_write));
                check_field("cmd_nack", int'(want.cmd_nack), int'(m_cmd_nack));
                check_field("cmd_byte", int'(want.cmd_byte), int'(m_cmd_byte));
                check_field("status", int'(want.status), int'(m_status));
                check_field("read_value", int'(want.read_value), int'(m_read_value));
                check_field("last", int'(want.last), int'(m_last));
            end
        end
    end

    // Stimulus
    initial begin
        i2cras_pkg::result_t first_addr_w;
        i2cras_pkg::result_t first_addr_r;
        i2cras_pkg::result_t stop_only;
        i2cras_pkg::result_t none;
        bus_event_t          ev;
        int                  sent;
        int                  drain;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mode          = i2cras_pkg::MODE_WRITE;
        s_device_addr   = 8'h00;
        s_reg_index     = 8'h00;
        s_write_value   = 8'h00;
        s_ack_missing   = 1'b0;
        s_received_byte = 8'h00;
        error_count     = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        model_phase     = BUS_IDLE;
        model_is_read   = 1'b0;
        model_device    = 8'h00;
        model_index     = 8'h00;
        model_value     = 8'h00;

        none         = '0;
        stop_only    = cmd_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        first_addr_w = cmd_word(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFE, 1'b1);
        first_addr_r = cmd_word(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);

        // idle noise, then a full write at the field extremes
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF),
                0, none, none);
        add_row(make_event(MODE_IGNORED, 8'h12, 8'h34, 8'h56, 1'b0, 8'h78), 0, none, none);
        add_row(make_event(i2cras_pkg::MODE_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b1, 8'h00),
                1, first_addr_w, none);
        add_row(make_event(i2cras_pkg::MODE_READ, 8'h77, 8'h88, 8'h99, 1'b0, 8'h11),
                0, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
                1, done_word(i2cras_pkg::STATUS_OK, 8'h00), none);
        // full read; the final byte carries a missing ack that must be ignored
        add_row(make_event(i2cras_pkg::MODE_READ, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00),
                1, first_addr_r, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF),
                1, done_word(i2cras_pkg::STATUS_OK, 8'hFF), none);
        // no device on the address byte
        add_row(make_event(i2cras_pkg::MODE_WRITE, 8'h5A, 8'h3C, 8'hC3, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00),
                2, stop_only, done_word(i2cras_pkg::STATUS_NODEV, 8'h00));
        // bad ack on the index byte
        add_row(make_event(i2cras_pkg::MODE_WRITE, 8'hA5, 8'hC3, 8'h3C, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00),
                2, stop_only, done_word(i2cras_pkg::STATUS_BADACK, 8'h00));
        // bad ack on the value byte still issues STOP
        add_row(make_event(i2cras_pkg::MODE_WRITE, 8'h81, 8'h7E, 8'h42, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00),
                2, stop_only, done_word(i2cras_pkg::STATUS_BADACK, 8'h00));
        // no device on the repeated-START address
        add_row(make_event(i2cras_pkg::MODE_READ, 8'h3B, 8'h10, 8'h00, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
                -1, none, none);
        add_row(make_event(i2cras_pkg::MODE_BYTE_DONE, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00),
                2, stop_only, done_word(i2cras_pkg::STATUS_NODEV, 8'h00));

        // hold reset, release at a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_event(directed_rows[i].ev, directed_rows[i].typed_n,
                       directed_rows[i].typed0, directed_rows[i].typed1);

        // random part in four idling phases
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case (sent * 4 / RANDOM_ITEMS)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            ev = random_event();
            send_event(ev, -1, none, none);
            sent++;
        end
        s_valid = 1'b0;

        // drain outstanding results, then let the pipeline settle
        drain = 0;
        while (awaited_results.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== i2c_register_access_sequencer_unit.f =====
design/i2cras_pkg.sv
design/i2cras_seq.sv
design/i2cras_outq.sv
design/i2c_register_access_sequencer_unit.sv
test/tb_top.sv
